### rtl/hll_pkg.sv
// shared types, constants and helper functions for the hyperloglog sketch update block
`default_nettype none
package hll_pkg;

  localparam int MaxIndexBits = 16;
  localparam int RankBits     = 6;
  localparam int OutIndexBits = 12;
  localparam int HashBits     = 32;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);

  localparam logic [HashBits-1:0] MixMulA = 32'h7feb352d;
  localparam logic [HashBits-1:0] MixMulB = 32'h846ca68b;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_ADD   = 2'd0;
  localparam mode_t MODE_MERGE = 2'd1;
  localparam mode_t MODE_READ  = 2'd2;

  typedef struct packed {
    logic                    wr;
    logic [MaxIndexBits-1:0] idx;
    logic [RankBits-1:0]     cand;
  } job_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [3:0] lzc8(input logic [7:0] v);
    logic [3:0] n;
    logic       found;
    n     = 4'd8;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 4'(7 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc32(input logic [31:0] w);
    logic [3:0] z3;
    logic [3:0] z2;
    logic [3:0] z1;
    logic [3:0] z0;
    logic [5:0] res;
    z3 = lzc8(w[31:24]);
    z2 = lzc8(w[23:16]);
    z1 = lzc8(w[15:8]);
    z0 = lzc8(w[7:0]);
    if (!z3[3]) begin
      res = 6'(z3);
    end else if (!z2[3]) begin
      res = 6'd8 + 6'(z2);
    end else if (!z1[3]) begin
      res = 6'd16 + 6'(z1);
    end else begin
      res = 6'd24 + 6'(z0);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/hyperloglog_sketch_update_top.sv
// top level of the hyperloglog sketch update block
//
// input stream s_axis: tuser carries the mode (add hash, merge register value,
// read register; the spare code acts as read), tdata carries hash, register
// index and merge rank. every transaction yields exactly one output
// transaction on m_axis with the register index, old value, new value and a
// changed flag, in input order.
// the path has six register stages: three front stages (two finalizer
// multiplies, then index and leading-zero count), the job queue, the memory
// read register and the output register.
// throughput is one transaction per cycle while m_axis does not stall and the
// memory is not being cleared; the register memory has one read port and one
// write port, with a bypass for back-to-back updates of the same register.
// after reset every register of the memory is swept to zero, during which
// s_axis_tready stays low.
// when m_axis stalls, the output register holds, the update stage and the
// four-entry queue fill, and then the front pipeline and s_axis_tready stop.
`default_nettype none
module hyperloglog_sketch_update_top #(
  parameter int INDEX_BITS = 12
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // hash [31:0], reg_index [43:32], merge_rank [49:44], zero fill [55:50]
  input  wire  [55:0] s_axis_tdata,
  // mode [1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // target_index [11:0], old_value [17:12], new_value [23:18], changed [24],
  // zero fill [31:25]
  output logic [31:0] m_axis_tdata
);

  logic                                front_valid;
  logic                                front_ready;
  hll_pkg::job_t                       front_job;
  logic                                q_valid;
  logic                                q_ready;
  hll_pkg::job_t                       q_job;
  hll_pkg::back_stat_t                 back_stat;
  logic [hll_pkg::OutIndexBits-1:0]    target_index;
  logic [hll_pkg::RankBits-1:0]        old_value;
  logic [hll_pkg::RankBits-1:0]        new_value;
  logic                                changed;

  hll_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (back_stat.clearing),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .mode       (hll_pkg::mode_t'(s_axis_tuser)),
    .hash       (s_axis_tdata[31:0]),
    .reg_index  (s_axis_tdata[43:32]),
    .merge_rank (s_axis_tdata[49:44]),
    .job_valid  (front_valid),
    .job_ready  (front_ready),
    .job        (front_job)
  );

  hll_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_job    (front_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  hll_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .job         (q_job),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_index   (target_index),
    .out_old     (old_value),
    .out_new     (new_value),
    .out_changed (changed),
    .stat        (back_stat)
  );

  assign m_axis_tdata = {7'd0, changed, new_value, old_value, target_index};

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    back_stat.clearing |-> !s_axis_tready)
    else $error("input accepted during memory clear");

  a_changed_means_raised: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (changed == (new_value > old_value)))
    else $error("changed flag does not match old and new values");

  a_unchanged_keeps_value: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !changed) |-> (new_value == old_value))
    else $error("register value moved without changed flag");
`endif

endmodule
`default_nettype wire

### rtl/hll_front.sv
// front pipeline: hash finalizer, register index select and rank computation
`default_nettype none
module hll_front #(
  parameter int INDEX_BITS = 12
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    hold,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire  hll_pkg::mode_t                   mode,
  input  wire  [hll_pkg::HashBits-1:0]           hash,
  input  wire  [hll_pkg::OutIndexBits-1:0]       reg_index,
  input  wire  [hll_pkg::RankBits-1:0]           merge_rank,
  output logic                                   job_valid,
  input  wire                                    job_ready,
  output hll_pkg::job_t                          job
);

  localparam int RestBits = hll_pkg::HashBits - INDEX_BITS;
  localparam logic [hll_pkg::MaxIndexBits-1:0] IdxMask =
    hll_pkg::MaxIndexBits'((32'd1 << INDEX_BITS) - 32'd1);
  localparam logic [hll_pkg::RankBits-1:0] EmptyRank = hll_pkg::RankBits'(RestBits + 1);

  logic                              en;
  logic                              accept;
  logic                              v1;
  logic                              v2;
  logic                              v3;
  logic [hll_pkg::HashBits-1:0]      h0;
  logic [hll_pkg::HashBits-1:0]      m1;
  logic [hll_pkg::HashBits-1:0]      p1;
  logic [hll_pkg::HashBits-1:0]      x1;
  logic [hll_pkg::HashBits-1:0]      m2;
  logic [hll_pkg::HashBits-1:0]      p2;
  logic [hll_pkg::HashBits-1:0]      f;
  logic [hll_pkg::HashBits-1:0]      w;
  logic [5:0]                        lz;
  logic [hll_pkg::RankBits-1:0]      rank;
  logic [hll_pkg::MaxIndexBits-1:0]  hidx;
  logic [hll_pkg::MaxIndexBits-1:0]  ridx;
  logic                              wr_in;
  logic                              add_in;
  logic                              wr1;
  logic                              wr2;
  logic                              add1;
  logic                              add2;
  logic [hll_pkg::MaxIndexBits-1:0]  idx1;
  logic [hll_pkg::MaxIndexBits-1:0]  idx2;
  logic [hll_pkg::RankBits-1:0]      cand1;
  logic [hll_pkg::RankBits-1:0]      cand2;
  hll_pkg::job_t                     job3;

  assign en        = !v3 || job_ready;
  assign in_ready  = en && !hold;
  assign accept    = in_valid && in_ready;
  assign job_valid = v3;
  assign job       = job3;

  // decode and first multiply
  assign add_in = (mode == hll_pkg::MODE_ADD);
  assign wr_in  = (mode == hll_pkg::MODE_ADD) || (mode == hll_pkg::MODE_MERGE);
  assign ridx   = hll_pkg::MaxIndexBits'(reg_index) & IdxMask;
  assign h0     = hash ^ (hash >> 16);
  assign m1     = h0 * hll_pkg::MixMulA;

  // second multiply
  assign x1 = p1 ^ (p1 >> 15);
  assign m2 = x1 * hll_pkg::MixMulB;

  // index and rank
  assign f    = p2 ^ (p2 >> 16);
  assign hidx = hll_pkg::MaxIndexBits'(f >> RestBits) & IdxMask;
  assign w    = f << INDEX_BITS;
  assign lz   = hll_pkg::lzc32(w);
  assign rank = (w == '0) ? EmptyRank : hll_pkg::RankBits'(lz + 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1         <= m1;
      wr1        <= wr_in;
      add1       <= add_in;
      idx1       <= ridx;
      cand1      <= merge_rank;
      p2         <= m2;
      wr2        <= wr1;
      add2       <= add1;
      idx2       <= idx1;
      cand2      <= cand1;
      job3.wr    <= wr2;
      job3.idx   <= add2 ? hidx : idx2;
      job3.cand  <= add2 ? rank : cand2;
    end
  end

endmodule
`default_nettype wire

### rtl/hll_fifo.sv
// short job queue between the front pipeline and the register update
`default_nettype none
module hll_fifo (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire hll_pkg::job_t  in_job,
  output logic                out_valid,
  input  wire                 out_ready,
  output hll_pkg::job_t       out_job
);

  hll_pkg::job_t                     slots [hll_pkg::QueueDepth];
  logic [hll_pkg::QueuePtrBits-1:0]  wptr;
  logic [hll_pkg::QueuePtrBits-1:0]  rptr;
  logic [hll_pkg::QueuePtrBits:0]    count;
  logic                              push;
  logic                              pop;

  assign in_ready  = (count != (hll_pkg::QueuePtrBits + 1)'(hll_pkg::QueueDepth));
  assign out_valid = (count != '0);
  assign out_job   = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_job;
    end
  end

endmodule
`default_nettype wire

### rtl/hll_back.sv
// rank register memory with clearing sweep, read-modify-write and output register
`default_nettype none
module hll_back #(
  parameter int INDEX_BITS = 12
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                job_valid,
  output logic                               job_ready,
  input  wire hll_pkg::job_t                 job,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [hll_pkg::OutIndexBits-1:0]   out_index,
  output logic [hll_pkg::RankBits-1:0]       out_old,
  output logic [hll_pkg::RankBits-1:0]       out_new,
  output logic                               out_changed,
  output hll_pkg::back_stat_t                stat
);

  localparam int Depth = 1 << INDEX_BITS;

  logic [hll_pkg::RankBits-1:0]  mem [Depth];
  logic                          clearing;
  logic [INDEX_BITS-1:0]         clr_idx;
  logic                          b_valid;
  hll_pkg::job_t                 b_job;
  logic [hll_pkg::RankBits-1:0]  b_rdata;
  logic                          b_fwd;
  logic [hll_pkg::RankBits-1:0]  b_fwd_data;
  logic [hll_pkg::RankBits-1:0]  b_old;
  logic [hll_pkg::RankBits-1:0]  b_new;
  logic                          b_chg;
  logic                          b_fire;
  logic                          o_free;
  logic                          pop;
  logic [INDEX_BITS-1:0]         rd_addr;
  logic [INDEX_BITS-1:0]         b_addr;

  assign stat.clearing = clearing;

  assign rd_addr   = job.idx[INDEX_BITS-1:0];
  assign b_addr    = b_job.idx[INDEX_BITS-1:0];
  assign o_free    = !out_valid || out_ready;
  assign b_fire    = b_valid && o_free;
  assign job_ready = !clearing && (!b_valid || o_free);
  assign pop       = job_valid && job_ready;

  // same-address write in the read cycle is forwarded
  assign b_old = b_fwd ? b_fwd_data : b_rdata;
  assign b_new = (b_job.wr && (b_job.cand > b_old)) ? b_job.cand : b_old;
  assign b_chg = (b_new != b_old);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == '1) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (b_fire && b_chg) begin
      mem[b_addr] <= b_new;
    end
    if (pop) begin
      b_rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_job      <= job;
      b_fwd      <= b_fire && (b_addr == rd_addr);
      b_fwd_data <= b_new;
    end
    if (b_fire) begin
      out_index   <= hll_pkg::OutIndexBits'(b_job.idx);
      out_old     <= b_old;
      out_new     <= b_new;
      out_changed <= b_chg;
    end
  end

endmodule
`default_nettype wire

### tb/hyperloglog_sketch_update_checker.sv
// checker for the hyperloglog sketch update block: tracks the sketch, predicts and compares results
`default_nettype none
module hyperloglog_sketch_update_checker #(
  parameter int INDEX_BITS = 12
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [55:0] s_axis_tdata,
  input  wire [1:0]  s_axis_tuser,
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [31:0] m_axis_tdata,
  output int         fail_count,
  output int         pending
);

  localparam int RestBits = hll_pkg::HashBits - INDEX_BITS;
  localparam int RegCount = 1 << INDEX_BITS;
  localparam int ExpDepth = 64;

  typedef struct packed {
    logic                             changed;
    logic [hll_pkg::RankBits-1:0]     new_value;
    logic [hll_pkg::RankBits-1:0]     old_value;
    logic [hll_pkg::OutIndexBits-1:0] target_index;
  } update_result_t;

  logic [hll_pkg::RankBits-1:0] sketch_regs [RegCount];
  update_result_t               expected_updates [ExpDepth];
  int                           exp_head = 0;
  int                           exp_tail = 0;

  function automatic logic [31:0] finalize_hash(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 16);
    x = x * hll_pkg::MixMulA;
    x = x ^ (x >> 15);
    x = x * hll_pkg::MixMulB;
    return x ^ (x >> 16);
  endfunction

  // 1 + leading zeros of the bits below the index
  function automatic logic [hll_pkg::RankBits-1:0] rank_of_rest(input logic [31:0] mixed);
    logic [hll_pkg::RankBits-1:0] rank;
    logic                         hit;
    rank = hll_pkg::RankBits'(RestBits + 1);
    hit  = 1'b0;
    for (int b = RestBits - 1; b >= 0; b--) begin
      if (!hit && mixed[b]) begin
        rank = hll_pkg::RankBits'(RestBits - b);
        hit  = 1'b1;
      end
    end
    return rank;
  endfunction

  function automatic update_result_t apply_sketch_update(input hll_pkg::mode_t mode,
                                                         input logic [31:0] hash,
                                                         input logic [11:0] reg_index,
                                                         input logic [5:0] merge_rank);
    logic [31:0]                  mixed;
    logic [INDEX_BITS-1:0]        slot;
    logic [hll_pkg::RankBits-1:0] cand;
    logic                         raise;
    update_result_t               r;
    cand  = '0;
    raise = 1'b0;
    slot  = INDEX_BITS'(reg_index);
    case (mode)
      hll_pkg::MODE_ADD: begin
        mixed = finalize_hash(hash);
        slot  = mixed[31 -: INDEX_BITS];
        cand  = rank_of_rest(mixed);
        raise = 1'b1;
      end
      hll_pkg::MODE_MERGE: begin
        cand  = merge_rank;
        raise = 1'b1;
      end
      default: begin
        raise = 1'b0;
      end
    endcase
    r.target_index = hll_pkg::OutIndexBits'(slot);
    r.old_value    = sketch_regs[slot];
    r.new_value    = r.old_value;
    if (raise && cand > r.old_value) begin
      r.new_value       = cand;
      sketch_regs[slot] = cand;
    end
    r.changed = (r.new_value > r.old_value);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    update_result_t got;
    update_result_t want;
    if (rst) begin
      foreach (sketch_regs[i]) sketch_regs[i] = '0;
      exp_head = 0;
      exp_tail = 0;
      pending <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = update_result_t'(m_axis_tdata[24:0]);
        if (exp_tail == exp_head) begin
          $error("result transaction with none expected: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_updates[exp_head % ExpDepth];
          exp_head++;
          check_field("target_index", want.target_index, got.target_index);
          check_field("old_value", want.old_value, got.old_value);
          check_field("new_value", want.new_value, got.new_value);
          check_field("changed", want.changed, got.changed);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_updates[exp_tail % ExpDepth] =
          apply_sketch_update(hll_pkg::mode_t'(s_axis_tuser), s_axis_tdata[31:0],
                              s_axis_tdata[43:32], s_axis_tdata[49:44]);
        exp_tail++;
      end
      pending <= exp_tail - exp_head;
    end
  end

endmodule
`default_nettype wire

### tb/tb_hyperloglog_sketch_update_top.sv
// testbench top for the hyperloglog sketch update block: stimulus, idling and verdict
`default_nettype none
module tb_hyperloglog_sketch_update_top;

  localparam int             IndexBits  = 12;
  localparam int             RestBits   = hll_pkg::HashBits - IndexBits;
  localparam int             CycleLimit = 200000;
  localparam int             PhaseItems = 150;
  localparam hll_pkg::mode_t MODE_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [11:0] hot_slots [8];

  hyperloglog_sketch_update_top #(
    .INDEX_BITS(IndexBits)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  hyperloglog_sketch_update_checker #(
    .INDEX_BITS(IndexBits)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] mul_inverse(input logic [31:0] a);
    logic [31:0] inv;
    inv = a;
    for (int i = 0; i < 5; i++) inv = inv * (32'd2 - a * inv);
    return inv;
  endfunction

  // inverse of the finalizer, so a hash can be aimed at a register and rank
  function automatic logic [31:0] unmix_hash(input logic [31:0] f);
    logic [31:0] h;
    h = f ^ (f >> 16);
    h = h * mul_inverse(hll_pkg::MixMulB);
    h = h ^ (h >> 15) ^ (h >> 30);
    h = h * mul_inverse(hll_pkg::MixMulA);
    return h ^ (h >> 16);
  endfunction

  function automatic logic [31:0] aimed_hash(input logic [11:0] slot, input logic [5:0] rank);
    logic [31:0] f;
    logic [31:0] rest_mask;
    f = 32'(slot) << RestBits;
    if (rank <= RestBits) begin
      rest_mask = (32'd1 << (RestBits - rank)) - 32'd1;
      f = f | (32'd1 << (RestBits - rank)) | ($urandom & rest_mask);
    end
    return unmix_hash(f);
  endfunction

  task automatic send_item(input hll_pkg::mode_t mode, input logic [31:0] hash,
                           input logic [11:0] reg_index, input logic [5:0] merge_rank);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, merge_rank, reg_index, hash};
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random_update();
    int          roll;
    logic [31:0] hash;
    logic [11:0] slot;
    logic [5:0]  rank;
    logic [5:0]  aim;
    roll = $urandom_range(99);
    hash = $urandom;
    slot = ($urandom_range(9) < 7) ? hot_slots[$urandom_range(7)] : 12'($urandom_range(4095));
    rank = ($urandom_range(1) == 1) ? 6'($urandom_range(22)) : 6'($urandom_range(63));
    aim  = ($urandom_range(1) == 1) ? 6'($urandom_range(RestBits + 1, 1)) : 6'($urandom_range(6, 1));
    if (roll < 45) send_item(hll_pkg::MODE_ADD, aimed_hash(slot, aim), slot, rank);
    else if (roll < 60) send_item(hll_pkg::MODE_ADD, hash, slot, rank);
    else if (roll < 80) send_item(hll_pkg::MODE_MERGE, hash, slot, rank);
    else if (roll < 95) send_item(hll_pkg::MODE_READ, hash, slot, rank);
    else send_item(MODE_SPARE, hash, slot, rank);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = hll_pkg::MODE_ADD;
    m_axis_tready = 1'b0;
    hot_slots[0]  = 12'd0;
    hot_slots[1]  = 12'd4095;
    hot_slots[2]  = 12'd123;
    for (int i = 3; i < 8; i++) hot_slots[i] = 12'($urandom_range(4095));
    send_idle_pct = 34;
    recv_idle_pct = 76;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_item(hll_pkg::MODE_READ, $urandom, 12'd0, 6'($urandom_range(63)));
    send_item(hll_pkg::MODE_READ, $urandom, 12'd4095, 6'($urandom_range(63)));
    send_item(MODE_SPARE, $urandom, 12'd4095, 6'd63);
    send_item(hll_pkg::MODE_MERGE, $urandom, 12'd0, 6'd63);
    send_item(hll_pkg::MODE_MERGE, $urandom, 12'd0, 6'd5);
    send_item(hll_pkg::MODE_MERGE, $urandom, 12'd0, 6'd63);
    send_item(hll_pkg::MODE_READ, $urandom, 12'd0, 6'd0);
    send_item(hll_pkg::MODE_MERGE, $urandom, 12'd4095, 6'd0);
    send_item(hll_pkg::MODE_MERGE, $urandom, 12'd4095, 6'd1);
    send_item(hll_pkg::MODE_ADD, 32'h0000_0000, 12'd0, 6'd0);
    send_item(hll_pkg::MODE_ADD, 32'hffff_ffff, 12'hfff, 6'd63);
    // rest bits all zero gives the top rank
    send_item(hll_pkg::MODE_ADD, aimed_hash(12'd4095, 6'(RestBits + 1)), 12'd0, 6'd0);
    send_item(hll_pkg::MODE_ADD, aimed_hash(12'd4095, 6'(RestBits + 1)), 12'd0, 6'd0);
    send_item(hll_pkg::MODE_ADD, aimed_hash(12'd4095, 6'(RestBits)), 12'd0, 6'd0);
    send_item(hll_pkg::MODE_ADD, aimed_hash(12'd0, 6'd1), 12'd0, 6'd0);
    send_item(hll_pkg::MODE_ADD, aimed_hash(12'd123, 6'd1), 12'd0, 6'd0);
    send_item(hll_pkg::MODE_ADD, aimed_hash(12'd123, 6'(RestBits + 1)), 12'd0, 6'd0);
    send_item(hll_pkg::MODE_READ, $urandom, 12'd123, 6'd0);
    send_item(MODE_SPARE, $urandom, 12'd123, 6'd63);
    send_item(hll_pkg::MODE_READ, $urandom, 12'd123, 6'd63);
    send_item(hll_pkg::MODE_MERGE, $urandom, 12'd4095, 6'd63);

    for (int i = 0; i < PhaseItems; i++) begin
      if (i == PhaseItems / 2) wait_drained();
      send_random_update();
    end
    wait_drained();

    send_idle_pct = 76;
    recv_idle_pct = 34;
    for (int i = 0; i < PhaseItems; i++) send_random_update();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < PhaseItems; i++) send_random_update();
    wait_drained();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
